FILE: src/tepc_pkg.sv
`timescale 1ns / 1ps
package tepc_pkg;
	localparam int MaxTriangles = 1024;
	localparam int CoordBits = 24;
	localparam int ThreshBits = 52;
	localparam int CountBits = $clog2(MaxTriangles + 1);
	localparam int TriIdxBits = (MaxTriangles > 1) ? $clog2(MaxTriangles) : 1;
	localparam int DiffBits = CoordBits + 1;
	localparam int SqBits = 2 * DiffBits;
	localparam int DistBits = SqBits + 2;

	typedef logic [1:0] mode_t;
	localparam mode_t ModeLoad = 2'd0;
	localparam mode_t ModeQuery = 2'd1;
	localparam mode_t ModeClear = 2'd2;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vtx_t;
endpackage

FILE: src/triangle_edge_presence_check_unit.sv
`timescale 1ns / 1ps
// Triangle edge presence check.
// Input channel (in_valid/in_ready) carries one item: mode plus nine coordinates.
//   mode load  : writes triangle (a,b,c) into the vertex store, dropped when full.
//   mode clear : empties the store (count to zero), no result.
//   mode query : scans all stored triangles and returns one result item with
//                edge_found and the floor midpoint of segment a-b.
//   mode 3     : ignored.
// Output channel (out_valid/out_ready) holds the result in an output register.
// Vertex store: three memories (x/y/z), one word per triangle holding its three
// vertices; one registered read port. Load and clear leave the unit idle.
// A query with N > 0 stored triangles reads them in order, one per cycle, then
// passes each through the read data, difference, square and sum stages
// (compare on the sum); once the pipe is seen empty, the output register is
// loaded. A match ends the scan early; an empty store skips the reads.
// No new item is taken until a query's scan has finished.
// A new item is taken while a previous result still waits in the output
// register, as long as the scan itself is idle; a new query waits for a free
// output register only at its end.
// Reset clears the triangle count, the control state and the match threshold;
// store contents are undefined until written. No clearing pass.
module triangle_edge_presence_check_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic signed [tepc_pkg::CoordBits-1:0] ax,
	input  logic signed [tepc_pkg::CoordBits-1:0] ay,
	input  logic signed [tepc_pkg::CoordBits-1:0] az,
	input  logic signed [tepc_pkg::CoordBits-1:0] bx,
	input  logic signed [tepc_pkg::CoordBits-1:0] by,
	input  logic signed [tepc_pkg::CoordBits-1:0] bz,
	input  logic signed [tepc_pkg::CoordBits-1:0] cx,
	input  logic signed [tepc_pkg::CoordBits-1:0] cy,
	input  logic signed [tepc_pkg::CoordBits-1:0] cz,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              edge_found,
	output logic signed [tepc_pkg::CoordBits-1:0] mid_x,
	output logic signed [tepc_pkg::CoordBits-1:0] mid_y,
	output logic signed [tepc_pkg::CoordBits-1:0] mid_z,
	input  logic                              cfg_we,
	input  logic [tepc_pkg::ThreshBits-1:0]   cfg_wdata
);
	localparam int CB = tepc_pkg::CoordBits;
	localparam int DB = tepc_pkg::DiffBits;
	localparam int SB = tepc_pkg::SqBits;
	localparam int TB = tepc_pkg::DistBits;
	localparam int NB = tepc_pkg::CountBits;
	localparam int IB = tepc_pkg::TriIdxBits;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef logic [3*CB-1:0] tri_word_t;

	state_t state_q;
	logic [NB-1:0] count_q;
	logic [NB-1:0] scan_q;
	logic [tepc_pkg::ThreshBits-1:0] thresh_q;
	tepc_pkg::coord_t pax_q, pay_q, paz_q, pbx_q, pby_q, pbz_q;
	logic found_q;

	// one word per triangle per axis: {v0, v1, v2}
	tri_word_t mem_x [tepc_pkg::MaxTriangles];
	tri_word_t mem_y [tepc_pkg::MaxTriangles];
	tri_word_t mem_z [tepc_pkg::MaxTriangles];
	tri_word_t rd_x, rd_y, rd_z;

	logic acc, do_load, issue, out_load;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [IB-1:0] rd_addr;

	assign acc = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign do_load = acc && (mode == tepc_pkg::ModeLoad) &&
		(count_q < NB'(tepc_pkg::MaxTriangles));
	assign issue = (state_q == ST_SCAN) && (scan_q < count_q) && !found_q;
	assign rd_addr = scan_q[IB-1:0];
	assign out_load = (state_q == ST_DONE) && (!out_valid || out_ready);

	always_ff @(posedge clk) begin
		if (do_load) begin
			mem_x[count_q[IB-1:0]] <= {ax, bx, cx};
			mem_y[count_q[IB-1:0]] <= {ay, by, cy};
			mem_z[count_q[IB-1:0]] <= {az, bz, cz};
		end
		rd_x <= mem_x[rd_addr];
		rd_y <= mem_y[rd_addr];
		rd_z <= mem_z[rd_addr];
	end

	// stage 2: differences, 6 per axis (3 vertices x 2 endpoints)
	logic signed [DB-1:0] dx_s2 [6], dy_s2 [6], dz_s2 [6];
	logic [SB-1:0] sx_s3 [6], sy_s3 [6], sz_s3 [6];
	logic [TB-1:0] d_s4 [6];

	function automatic logic signed [DB-1:0] vdiff(input tri_word_t w, input int k,
		input tepc_pkg::coord_t p);
		logic signed [CB-1:0] v;
		v = w[(2-k)*CB +: CB];
		return DB'(v) - DB'(p);
	endfunction

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			dx_s2[k] <= vdiff(rd_x, k, pax_q);
			dy_s2[k] <= vdiff(rd_y, k, pay_q);
			dz_s2[k] <= vdiff(rd_z, k, paz_q);
			dx_s2[k+3] <= vdiff(rd_x, k, pbx_q);
			dy_s2[k+3] <= vdiff(rd_y, k, pby_q);
			dz_s2[k+3] <= vdiff(rd_z, k, pbz_q);
		end
		for (int k = 0; k < 6; k++) begin
			sx_s3[k] <= SB'(dx_s2[k] * dx_s2[k]);
			sy_s3[k] <= SB'(dy_s2[k] * dy_s2[k]);
			sz_s3[k] <= SB'(dz_s2[k] * dz_s2[k]);
			d_s4[k] <= TB'(sx_s3[k]) + TB'(sy_s3[k]) + TB'(sz_s3[k]);
		end
	end

	logic [2:0] m1, m2;
	logic hit;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m1[k] = d_s4[k] <= TB'(thresh_q);
			m2[k] = d_s4[k+3] <= TB'(thresh_q);
		end
		hit = (m1[0] && (m2[1] || m2[2])) || (m1[1] && (m2[0] || m2[2])) ||
			(m1[2] && (m2[0] || m2[1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q <= '0;
			thresh_q <= '0;
			found_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) thresh_q <= cfg_wdata;
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (v_s4 && hit) found_q <= 1'b1;
			if (issue) scan_q <= scan_q + NB'(1);
			case (state_q)
				ST_IDLE: begin
					if (do_load) count_q <= count_q + NB'(1);
					if (acc && mode == tepc_pkg::ModeClear) count_q <= '0;
					if (acc && mode == tepc_pkg::ModeQuery) begin
						state_q <= ST_SCAN;
						scan_q <= '0;
						found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (!issue && !v_s1 && !v_s2 && !v_s3 && !v_s4)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && mode == tepc_pkg::ModeQuery) begin
			pax_q <= ax; pay_q <= ay; paz_q <= az;
			pbx_q <= bx; pby_q <= by; pbz_q <= bz;
		end
		if (out_load) begin
			edge_found <= found_q;
			mid_x <= CB'((DB'(pax_q) + DB'(pbx_q)) >>> 1);
			mid_y <= CB'((DB'(pay_q) + DB'(pby_q)) >>> 1);
			mid_z <= CB'((DB'(paz_q) + DB'(pbz_q)) >>> 1);
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NB'(tepc_pkg::MaxTriangles))
		else $error("triangle count above store size");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> scan_q < count_q)
		else $error("scan past stored triangles");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result without finished scan");
	a_count_stable_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> $stable(count_q))
		else $error("store changed during scan");
endmodule
